// ===== hdl/brs_pkg.sv =====
// ----------------------------------------------------------------------------
// brs_pkg
// Shared types, constants and trig/palette helpers for the bouncing,
// rotating square generator.
// ----------------------------------------------------------------------------
`default_nettype none

package brs_pkg;

  // Fixed-point formats.
  localparam int FRACTION_BITS      = 4;
  localparam int SINE_FRACTION_BITS = 14;
  localparam int PALETTE_ENTRIES    = 7;

  // Field widths.
  localparam int SCREEN_W = 12;
  localparam int RADIUS_W = 10;
  localparam int COORD_W  = 14;
  localparam int COLOR_W  = 8;
  localparam int ANGLE_W  = 9;
  localparam int PADDR_W  = 3;
  localparam int PDATA_W  = 32;

  // Derived internal widths.
  localparam int CENTER_W = SCREEN_W + FRACTION_BITS;
  localparam int POS_W    = CENTER_W + 2;
  localparam int VEL_W    = (FRACTION_BITS + 3 > 8) ? FRACTION_BITS + 3 : 8;
  localparam int TRIG_W   = SINE_FRACTION_BITS + 2;
  localparam int PROD_W   = TRIG_W + RADIUS_W + 1;
  localparam int NUM_W    = CENTER_W + SINE_FRACTION_BITS + 3;
  localparam int SHIFT    = FRACTION_BITS + SINE_FRACTION_BITS;
  localparam int PAL_W    = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  // Reset values and limits.
  localparam logic [CENTER_W-1:0]     CENTER_RESET   = CENTER_W'(10 << FRACTION_BITS);
  localparam logic signed [VEL_W-1:0] VELOCITY_RESET = VEL_W'(5 << (FRACTION_BITS - 1));
  localparam logic [RADIUS_W-1:0]     RADIUS_RESET   = RADIUS_W'(200);
  localparam int                      VEL_ABS_MAX    = 127;
  localparam logic [ANGLE_W-1:0]      ANGLE_LAST     = ANGLE_W'(359);
  localparam logic [ANGLE_W-1:0]      ANGLE_FULL     = ANGLE_W'(360);
  localparam logic [ANGLE_W-1:0]      ANGLE_QUARTER  = ANGLE_W'(90);
  localparam logic [ANGLE_W-1:0]      ANGLE_HALF     = ANGLE_W'(180);
  localparam logic [ANGLE_W-1:0]      ANGLE_3QUARTER = ANGLE_W'(270);

  // Rescaling of the Q1.14 table to the chosen sine precision.
  localparam int          SINE_DOWN = (SINE_FRACTION_BITS <= 14) ? 14 - SINE_FRACTION_BITS : 0;
  localparam int          SINE_UP   = (SINE_FRACTION_BITS > 14) ? SINE_FRACTION_BITS - 14 : 0;
  localparam logic [31:0] SINE_HALF = 32'((1 << SINE_DOWN) >> 1);

  // Rounding bias for truncation toward zero of a negative numerator.
  localparam logic signed [NUM_W-1:0] TRUNC_BIAS = NUM_W'((64'd1 << SHIFT) - 64'd1);

  // Configuration register indexes (word address).
  typedef enum logic {
    REG_SQUARE_RADIUS = 1'b0
  } reg_index_t;

  typedef struct packed {
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } color_t;

  // One frame's snapshot of the motion state.
  typedef struct packed {
    logic [CENTER_W-1:0] cx;
    logic [CENTER_W-1:0] cy;
    logic [ANGLE_W-1:0]  angle;
    logic [PAL_W-1:0]    palette;
  } frame_t;

  // Quarter-wave sine, Q1.14, whole degrees 0..90.
  localparam logic [15:0] SINE_Q14 [0:90] = '{
    16'd0,     16'd286,   16'd572,   16'd857,   16'd1143,  16'd1428,  16'd1713,
    16'd1997,  16'd2280,  16'd2563,  16'd2845,  16'd3126,  16'd3406,  16'd3686,
    16'd3964,  16'd4240,  16'd4516,  16'd4790,  16'd5063,  16'd5334,  16'd5604,
    16'd5872,  16'd6138,  16'd6402,  16'd6664,  16'd6924,  16'd7182,  16'd7438,
    16'd7692,  16'd7943,  16'd8192,  16'd8438,  16'd8682,  16'd8923,  16'd9162,
    16'd9397,  16'd9630,  16'd9860,  16'd10087, 16'd10311, 16'd10531, 16'd10749,
    16'd10963, 16'd11174, 16'd11381, 16'd11585, 16'd11786, 16'd11982, 16'd12176,
    16'd12365, 16'd12551, 16'd12733, 16'd12911, 16'd13085, 16'd13255, 16'd13421,
    16'd13583, 16'd13741, 16'd13894, 16'd14044, 16'd14189, 16'd14330, 16'd14466,
    16'd14598, 16'd14726, 16'd14849, 16'd14968, 16'd15082, 16'd15191, 16'd15296,
    16'd15396, 16'd15491, 16'd15582, 16'd15668, 16'd15749, 16'd15826, 16'd15897,
    16'd15964, 16'd16026, 16'd16083, 16'd16135, 16'd16182, 16'd16225, 16'd16262,
    16'd16294, 16'd16322, 16'd16344, 16'd16362, 16'd16374, 16'd16382, 16'd16384
  };

  function automatic logic signed [TRIG_W-1:0] quarter_sine(input logic [6:0] idx);
    logic [31:0] v;
    v = 32'(SINE_Q14[idx]);
    v = ((v + SINE_HALF) >> SINE_DOWN) << SINE_UP;
    return TRIG_W'(v);
  endfunction

  // Sine of a whole angle in 0..359 degrees.
  function automatic logic signed [TRIG_W-1:0] sine_deg(input logic [ANGLE_W-1:0] deg);
    logic [1:0]                quad;
    logic [ANGLE_W-1:0]        rem;
    logic [6:0]                idx;
    logic signed [TRIG_W-1:0]  mag;
    if (deg >= ANGLE_3QUARTER) begin
      quad = 2'd3;
      rem  = deg - ANGLE_3QUARTER;
    end else if (deg >= ANGLE_HALF) begin
      quad = 2'd2;
      rem  = deg - ANGLE_HALF;
    end else if (deg >= ANGLE_QUARTER) begin
      quad = 2'd1;
      rem  = deg - ANGLE_QUARTER;
    end else begin
      quad = 2'd0;
      rem  = deg;
    end
    idx = quad[0] ? 7'(ANGLE_QUARTER - rem) : 7'(rem);
    mag = quarter_sine(idx);
    return quad[1] ? -mag : mag;
  endfunction

  function automatic logic signed [TRIG_W-1:0] cosine_deg(input logic [ANGLE_W-1:0] deg);
    logic [ANGLE_W-1:0] shifted;
    shifted = deg + ANGLE_QUARTER;
    if (shifted >= ANGLE_FULL) begin
      shifted = shifted - ANGLE_FULL;
    end
    return sine_deg(shifted);
  endfunction

  // Pixel coordinate of center plus a scaled offset, truncated toward zero.
  function automatic logic signed [COORD_W-1:0] corner_pixel(
    input logic [CENTER_W-1:0]      center,
    input logic signed [PROD_W-1:0] offset
  );
    logic signed [NUM_W-1:0] num;
    logic signed [NUM_W-1:0] res;
    num = $signed(NUM_W'(center)) <<< SINE_FRACTION_BITS;
    num = num + (NUM_W'(offset) <<< FRACTION_BITS);
    if (num[NUM_W-1]) begin
      num = num + TRUNC_BIAS;
    end
    res = num >>> SHIFT;
    return res[COORD_W-1:0];
  endfunction

  function automatic color_t palette_color(input logic [3:0] idx);
    color_t c;
    case (idx)
      4'd0:    c = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
      4'd1:    c = '{red: 8'd0,   green: 8'd255, blue: 8'd0};
      4'd2:    c = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};
      4'd3:    c = '{red: 8'd255, green: 8'd255, blue: 8'd255};
      4'd4:    c = '{red: 8'd255, green: 8'd0,   blue: 8'd255};
      4'd5:    c = '{red: 8'd0,   green: 8'd255, blue: 8'd255};
      4'd6:    c = '{red: 8'd255, green: 8'd255, blue: 8'd0};
      default: c = '{red: 8'd0,   green: 8'd0,   blue: 8'd0};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/brs_if.sv =====
// ----------------------------------------------------------------------------
// brs_if
// Valid/ready channels: frame ticks in, square edges out.
// ----------------------------------------------------------------------------
`default_nettype none

interface brs_in_if import brs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SCREEN_W-1:0] screen_width;
  logic [SCREEN_W-1:0] screen_height;

  modport source (output valid, output screen_width, output screen_height, input ready);
  modport sink   (input valid, input screen_width, input screen_height, output ready);
endinterface

interface brs_out_if import brs_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] edge_start_x;
  logic signed [COORD_W-1:0] edge_start_y;
  logic signed [COORD_W-1:0] edge_end_x;
  logic signed [COORD_W-1:0] edge_end_y;
  logic [COLOR_W-1:0]        color_red;
  logic [COLOR_W-1:0]        color_green;
  logic [COLOR_W-1:0]        color_blue;
  logic                      last_edge;

  modport source (
    output valid, output edge_start_x, output edge_start_y, output edge_end_x,
    output edge_end_y, output color_red, output color_green, output color_blue,
    output last_edge, input ready
  );
  modport sink (
    input valid, input edge_start_x, input edge_start_y, input edge_end_x,
    input edge_end_y, input color_red, input color_green, input color_blue,
    input last_edge, output ready
  );
endinterface

`default_nettype wire

// ===== hdl/brs_motion.sv =====
// ----------------------------------------------------------------------------
// brs_motion
// Holds the square's motion state, snapshots it for each accepted tick and
// advances position, velocity, angle, spin and palette.
// ----------------------------------------------------------------------------
`default_nettype none

module brs_motion import brs_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  brs_in_if.sink    frame_in,
  output frame_t    frame,
  output logic      frame_valid,
  input  wire logic frame_take
);

  logic [CENTER_W-1:0]     center_x, center_y;
  logic [CENTER_W-1:0]     center_x_next, center_y_next;
  logic signed [VEL_W-1:0] velocity_x, velocity_y;
  logic signed [VEL_W-1:0] velocity_x_next, velocity_y_next;
  logic [ANGLE_W-1:0]      angle_degrees, angle_degrees_next;
  logic                    spin_negative, spin_negative_next;
  logic [PAL_W-1:0]        palette_index, palette_index_next;
  logic                    accept;

  function automatic logic signed [VEL_W-1:0] bounded_abs(input logic signed [VEL_W-1:0] v);
    logic signed [VEL_W:0] wide;
    wide = (VEL_W + 1)'(v);
    if (wide[VEL_W]) begin
      wide = -wide;
    end
    if (wide > VEL_ABS_MAX) begin
      wide = (VEL_W + 1)'(VEL_ABS_MAX);
    end
    return VEL_W'(wide);
  endfunction

  // Move one axis and clamp it to [0, bound], turning the velocity inward.
  function automatic logic [CENTER_W+VEL_W:0] step_axis(
    input logic [CENTER_W-1:0]     pos,
    input logic signed [VEL_W-1:0] vel,
    input logic [SCREEN_W-1:0]     size
  );
    logic signed [POS_W-1:0] p;
    logic signed [POS_W-1:0] bound;
    logic signed [VEL_W-1:0] v;
    logic                    hit;
    p     = $signed(POS_W'(pos)) + POS_W'(vel);
    bound = $signed(POS_W'(size) << FRACTION_BITS);
    v     = vel;
    hit   = 1'b0;
    if (p[POS_W-1]) begin
      p   = '0;
      v   = bounded_abs(v);
      hit = 1'b1;
    end
    if (p > bound) begin
      p   = bound;
      v   = -bounded_abs(v);
      hit = 1'b1;
    end
    return {hit, v, p[CENTER_W-1:0]};
  endfunction

  logic hit_x, hit_y, bounce;

  assign accept         = frame_in.valid && frame_in.ready;
  assign frame_in.ready = !frame_valid || frame_take;

  always_comb begin
    {hit_x, velocity_x_next, center_x_next} =
      step_axis(center_x, velocity_x, frame_in.screen_width);
    {hit_y, velocity_y_next, center_y_next} =
      step_axis(center_y, velocity_y, frame_in.screen_height);
    bounce = hit_x || hit_y;

    if (spin_negative) begin
      angle_degrees_next = (angle_degrees == '0) ? ANGLE_LAST : angle_degrees - 1'b1;
    end else begin
      angle_degrees_next = (angle_degrees == ANGLE_LAST) ? '0 : angle_degrees + 1'b1;
    end

    spin_negative_next = spin_negative ^ bounce;
    palette_index_next = palette_index;
    if (bounce) begin
      palette_index_next = (palette_index == PAL_W'(PALETTE_ENTRIES - 1)) ?
                           '0 : palette_index + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= CENTER_RESET;
      center_y      <= CENTER_RESET;
      velocity_x    <= VELOCITY_RESET;
      velocity_y    <= VELOCITY_RESET;
      angle_degrees <= '0;
      spin_negative <= 1'b0;
      palette_index <= '0;
      frame_valid   <= 1'b0;
    end else begin
      if (accept) begin
        center_x      <= center_x_next;
        center_y      <= center_y_next;
        velocity_x    <= velocity_x_next;
        velocity_y    <= velocity_y_next;
        angle_degrees <= angle_degrees_next;
        spin_negative <= spin_negative_next;
        palette_index <= palette_index_next;
        frame_valid   <= 1'b1;
      end else if (frame_take) begin
        frame_valid <= 1'b0;
      end
    end
  end

  // The snapshot is the state as it stood before this tick's update.
  always_ff @(posedge clk) begin
    if (accept) begin
      frame <= '{cx: center_x, cy: center_y, angle: angle_degrees, palette: palette_index};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/brs_edge_gen.sv =====
// ----------------------------------------------------------------------------
// brs_edge_gen
// Scales sine and cosine of the frame angle by the radius once per frame, then
// emits the edges to an output register, one per cycle unless edge_out stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module brs_edge_gen import brs_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [RADIUS_W-1:0] radius,
  input  wire frame_t              frame,
  input  wire logic                frame_valid,
  output logic                     frame_take,
  brs_out_if.source                edge_out
);

  typedef struct packed {
    logic signed [PROD_W-1:0] x;
    logic signed [PROD_W-1:0] y;
  } offset_t;

  // Corner j lies at angle + 90*j: its offset from the center in r*cos, r*sin.
  function automatic offset_t corner_offset(
    input logic [1:0]               j,
    input logic signed [PROD_W-1:0] s,
    input logic signed [PROD_W-1:0] c
  );
    offset_t o;
    case (j)
      2'd0:    o = '{x: c,  y: s};
      2'd1:    o = '{x: -s, y: c};
      2'd2:    o = '{x: -c, y: -s};
      default: o = '{x: s,  y: -c};
    endcase
    return o;
  endfunction

  logic                     b_valid;
  logic signed [PROD_W-1:0] b_sin_r, b_cos_r;
  logic [CENTER_W-1:0]      b_cx, b_cy;
  color_t                   b_color;
  logic [1:0]               edge_idx;

  logic                     out_valid;
  logic signed [COORD_W-1:0] out_sx, out_sy, out_ex, out_ey;
  color_t                   out_color;
  logic                     out_last;

  logic                     emit, last, b_load;
  logic signed [TRIG_W-1:0] sin_v, cos_v;
  logic signed [PROD_W-1:0] radius_s;
  offset_t                  start_off, end_off;

  assign emit       = b_valid && (!out_valid || edge_out.ready);
  assign last       = (edge_idx == 2'd3);
  assign b_load     = frame_valid && (!b_valid || (emit && last));
  assign frame_take = b_load;

  always_comb begin
    sin_v     = sine_deg(frame.angle);
    cos_v     = cosine_deg(frame.angle);
    radius_s  = $signed(PROD_W'(radius));
    start_off = corner_offset(edge_idx, b_sin_r, b_cos_r);
    end_off   = corner_offset(edge_idx + 2'd1, b_sin_r, b_cos_r);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      edge_idx  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (b_load) begin
        b_valid  <= 1'b1;
        edge_idx <= '0;
      end else if (emit) begin
        edge_idx <= edge_idx + 2'd1;
        if (last) begin
          b_valid <= 1'b0;
        end
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (edge_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      b_sin_r <= PROD_W'(sin_v) * radius_s;
      b_cos_r <= PROD_W'(cos_v) * radius_s;
      b_cx    <= frame.cx;
      b_cy    <= frame.cy;
      b_color <= palette_color(4'(frame.palette));
    end
    if (emit) begin
      out_sx    <= corner_pixel(b_cx, start_off.x);
      out_sy    <= corner_pixel(b_cy, start_off.y);
      out_ex    <= corner_pixel(b_cx, end_off.x);
      out_ey    <= corner_pixel(b_cy, end_off.y);
      out_color <= b_color;
      out_last  <= last;
    end
  end

  assign edge_out.valid        = out_valid;
  assign edge_out.edge_start_x = out_sx;
  assign edge_out.edge_start_y = out_sy;
  assign edge_out.edge_end_x   = out_ex;
  assign edge_out.edge_end_y   = out_ey;
  assign edge_out.color_red    = out_color.red;
  assign edge_out.color_green  = out_color.green;
  assign edge_out.color_blue   = out_color.blue;
  assign edge_out.last_edge    = out_last;

endmodule

`default_nettype wire

// ===== hdl/bouncing_rotating_square.sv =====
// ----------------------------------------------------------------------------
// bouncing_rotating_square
// For each frame tick, emits the edges of a rotating square that bounces
// inside the screen, and advances its motion, spin and color.
// ----------------------------------------------------------------------------
//
//   channel    dir   role                 beat carries
//   ---------  ----  -------------------  -------------------------------------
//   frame_in   in    valid/ready sink     screen_width, screen_height
//   edge_out   out   valid/ready source   edge corners, color, last_edge
//   APB        in    config slave         square_radius at byte address 0
//
// Every accepted tick yields a beat per edge, one per cycle while edge_out is
// ready, the last with last_edge set. With edge_out always ready, the pace of
// ticks is set by the single edge emitter, which produces one edge per cycle.
// The first edge of a tick passes through the motion snapshot, the register
// of the radius-scaled sine and cosine, and the output register. Reset (rst,
// synchronous) restores the start position, velocity, angle, spin, palette
// and radius. When edge_out stalls, the pending edge holds in the output
// register and backpressure reaches frame_in.ready.
// ----------------------------------------------------------------------------
`default_nettype none

module bouncing_rotating_square import brs_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  // Configuration port.
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [PDATA_W-1:0] pwdata,
  output logic      [PDATA_W-1:0] prdata,
  output logic                    pready,
  // Streams.
  brs_in_if.sink                  frame_in,
  brs_out_if.source               edge_out
);

  // The radius register. Writes land at the access phase; the port never
  // inserts wait states. Only the word index is decoded, so byte offsets
  // inside the word alias to the same register.
  logic [RADIUS_W-1:0] square_radius;
  logic                cfg_write;
  logic                radius_sel;

  assign pready     = 1'b1;
  assign radius_sel = (paddr[2] == REG_SQUARE_RADIUS);
  assign cfg_write  = psel && penable && pwrite && pready;
  assign prdata     = radius_sel ? PDATA_W'(square_radius) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      square_radius <= RADIUS_RESET;
    end else if (cfg_write && radius_sel) begin
      square_radius <= pwdata[RADIUS_W-1:0];
    end
  end

  // The motion block snapshots the state of each tick and updates it; the
  // edge generator turns one snapshot into the square's edges.
  frame_t frame;
  logic   frame_valid;
  logic   frame_take;

  brs_motion u_motion (
    .clk         (clk),
    .rst         (rst),
    .frame_in    (frame_in),
    .frame       (frame),
    .frame_valid (frame_valid),
    .frame_take  (frame_take)
  );

  brs_edge_gen u_edge_gen (
    .clk         (clk),
    .rst         (rst),
    .radius      (square_radius),
    .frame       (frame),
    .frame_valid (frame_valid),
    .frame_take  (frame_take),
    .edge_out    (edge_out)
  );

endmodule

`default_nettype wire

// ===== verif/tb_bouncing_rotating_square.sv =====
// ----------------------------------------------------------------------------
// tb_bouncing_rotating_square
// Self-checking bench for the bouncing, rotating square generator. Frame ticks
// go in on a valid/ready channel and every tick is predicted as its edge
// beats. A small motion model is kept for this: center, velocity, angle, spin
// and palette. Each edge beat that leaves the block is checked field by field
// against the oldest predicted beat. The radius register is written and read
// back over APB between phases, while no beat is in flight.
// ----------------------------------------------------------------------------

module tb_bouncing_rotating_square import brs_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // The limit is far above the slowest legal run. That run is about 420 ticks
  // whose every edge beat is held up by a long receiver gap, plus the long
  // hold-off and the register accesses.
  localparam int LIMIT_CYCLES    = 400000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 12;
  localparam int MAX_REPORTS     = 40;
  localparam int DEFAULT_RADIUS  = 200;
  localparam int EDGES_PER_TICK  = 4;

  // The radius register sits at byte address 0. The next word, index 1, is
  // unmapped, so writes to it must be dropped.
  localparam logic [PADDR_W-1:0] RADIUS_ADDR = PADDR_W'(4 * int'(REG_SQUARE_RADIUS));
  localparam logic [PADDR_W-1:0] UNUSED_ADDR = PADDR_W'(4 * (int'(REG_SQUARE_RADIUS) + 1));

  // Quarter-wave sine in Q1.14, one entry per whole degree from 0 to 90.
  localparam int QUARTER_WAVE [0:90] = '{
        0,   286,   572,   857,  1143,  1428,  1713,  1997,  2280,  2563,
     2845,  3126,  3406,  3686,  3964,  4240,  4516,  4790,  5063,  5334,
     5604,  5872,  6138,  6402,  6664,  6924,  7182,  7438,  7692,  7943,
     8192,  8438,  8682,  8923,  9162,  9397,  9630,  9860, 10087, 10311,
    10531, 10749, 10963, 11174, 11381, 11585, 11786, 11982, 12176, 12365,
    12551, 12733, 12911, 13085, 13255, 13421, 13583, 13741, 13894, 14044,
    14189, 14330, 14466, 14598, 14726, 14849, 14968, 15082, 15191, 15296,
    15396, 15491, 15582, 15668, 15749, 15826, 15897, 15964, 16026, 16083,
    16135, 16182, 16225, 16262, 16294, 16322, 16344, 16362, 16374, 16382,
    16384
  };

  // The seven palette colors as {red, green, blue}. Any further entry is black.
  localparam logic [23:0] PALETTE_RGB [0:6] = '{
    24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFFFF,
    24'hFF00FF, 24'h00FFFF, 24'hFFFF00
  };

  typedef struct {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic [COLOR_W-1:0]        red;
    logic [COLOR_W-1:0]        green;
    logic [COLOR_W-1:0]        blue;
    logic                      last_edge;
  } square_edge_t;

  // Clock, reset and the APB port.
  logic               clk = 1'b0;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  brs_in_if  frame_if ();
  brs_out_if edge_if ();

  bouncing_rotating_square dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .frame_in (frame_if),
    .edge_out (edge_if)
  );

  always #5 clk = ~clk;

  // Motion state of the square as this bench sees it. Center and velocity
  // are in Q.FRACTION_BITS, exactly as the block keeps them.
  int  square_radius;
  int  square_cx;
  int  square_cy;
  int  square_vx;
  int  square_vy;
  int  square_angle;
  bit  spin_reversed;
  int  square_palette;

  square_edge_t pending_edges[$];

  // Run bookkeeping.
  int  failures;
  int  cycle_count;
  int  ticks_taken;
  int  edges_checked;
  int  bounce_count;
  int  radius_writes;

  // Receiver controls, used by the tests that shape backpressure.
  bit  hold_off_request;
  bit  ready_steady;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------

  function automatic void reset_square();
    square_radius  = DEFAULT_RADIUS;
    square_cx      = 10 << FRACTION_BITS;
    square_cy      = 10 << FRACTION_BITS;
    square_vx      = 5 << (FRACTION_BITS - 1);
    square_vy      = 5 << (FRACTION_BITS - 1);
    square_angle   = 0;
    spin_reversed  = 1'b0;
    square_palette = 0;
  endfunction

  // Sine of a whole angle in degrees, at SINE_FRACTION_BITS of precision.
  // Below 14 bits the table is rounded by half an LSB, above it is widened.
  function automatic int sine_of(input int degrees);
    int deg;
    int quadrant;
    int offset;
    int value;
    deg      = degrees % 360;
    quadrant = deg / 90;
    offset   = deg % 90;
    value    = QUARTER_WAVE[(quadrant % 2 == 1) ? 90 - offset : offset];
    if (SINE_FRACTION_BITS <= 14) begin
      value = (value + ((1 << (14 - SINE_FRACTION_BITS)) >> 1)) >>> (14 - SINE_FRACTION_BITS);
    end else begin
      value = value << (SINE_FRACTION_BITS - 14);
    end
    return (quadrant >= 2) ? -value : value;
  endfunction

  // Pixel coordinate of center + trig * radius. The sum is exact before the
  // final division, and the division truncates toward zero.
  function automatic logic signed [COORD_W-1:0] corner_of(input int center, input int trig);
    longint numer;
    longint pixel;
    numer = longint'(center) * (longint'(1) << SINE_FRACTION_BITS)
          + longint'(trig) * longint'(square_radius) * (longint'(1) << FRACTION_BITS);
    if (numer < 0) begin
      pixel = -((-numer) >>> (FRACTION_BITS + SINE_FRACTION_BITS));
    end else begin
      pixel = numer >>> (FRACTION_BITS + SINE_FRACTION_BITS);
    end
    return pixel[COORD_W-1:0];
  endfunction

  // The speed after a bounce. A magnitude of 128 cannot be stored as +128,
  // so it is held at 127.
  function automatic int bounced_speed(input int velocity);
    int speed;
    speed = (velocity < 0) ? -velocity : velocity;
    return (speed > 127) ? 127 : speed;
  endfunction

  // One frame tick. The edges come from the motion state as it stands
  // now; after them the angle, center, velocity, spin and color move on.
  function automatic void advance_square(input int width_px, input int height_px);
    int           right_bound;
    int           bottom_bound;
    int           turn;
    logic [23:0]  rgb;
    bit           bounced;
    square_edge_t beat;
    right_bound  = width_px << FRACTION_BITS;
    bottom_bound = height_px << FRACTION_BITS;
    rgb = 24'h000000;
    if (square_palette < 7) begin
      rgb = PALETTE_RGB[square_palette];
    end
    for (int k = 0; k < EDGES_PER_TICK; k++) begin
      turn           = square_angle + 90 * k;
      beat.start_x   = corner_of(square_cx, sine_of(turn + 90));
      beat.start_y   = corner_of(square_cy, sine_of(turn));
      beat.end_x     = corner_of(square_cx, sine_of(turn + 180));
      beat.end_y     = corner_of(square_cy, sine_of(turn + 90));
      beat.red       = rgb[23:16];
      beat.green     = rgb[15:8];
      beat.blue      = rgb[7:0];
      beat.last_edge = (k == EDGES_PER_TICK - 1);
      pending_edges.push_back(beat);
    end

    square_angle = (square_angle + (spin_reversed ? 359 : 1)) % 360;
    square_cx += square_vx;
    square_cy += square_vy;

    // The clamps run left, right, top, bottom. On a zero-size screen one
    // check of the axis fires on every tick and the center ends at 0.
    bounced = 1'b0;
    if (square_cx < 0) begin
      square_cx = 0;
      square_vx = bounced_speed(square_vx);
      bounced   = 1'b1;
    end
    if (square_cx > right_bound) begin
      square_cx = right_bound;
      square_vx = -bounced_speed(square_vx);
      bounced   = 1'b1;
    end
    if (square_cy < 0) begin
      square_cy = 0;
      square_vy = bounced_speed(square_vy);
      bounced   = 1'b1;
    end
    if (square_cy > bottom_bound) begin
      square_cy = bottom_bound;
      square_vy = -bounced_speed(square_vy);
      bounced   = 1'b1;
    end
    if (bounced) begin
      square_palette = (square_palette + 1) % PALETTE_ENTRIES;
      spin_reversed  = !spin_reversed;
      bounce_count++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------

  // Every failure is counted. Only the first few are printed, so that a badly
  // broken block cannot flood the log.
  task automatic log_failure(input string msg);
    failures++;
    if (failures <= MAX_REPORTS) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
  endtask

  task automatic check_field(input string field, input logic signed [15:0] got,
                             input logic signed [15:0] want);
    if (got !== want) begin
      log_failure($sformatf("edge beat %0d, %s: got %0d, expected %0d",
                            edges_checked, field, got, want));
    end
  endtask

  // Both handshakes are sampled at the rising edge. All drivers use
  // nonblocking assignments, so the values seen here are the ones that were
  // stable just before the edge. A tick is predicted before the edge beat of
  // the same edge is checked. This order does not matter: a tick's first edge
  // leaves only after its snapshot, scaled trig and output registers.
  always @(posedge clk) begin
    square_edge_t want;
    if (!rst) begin
      if (frame_if.valid && frame_if.ready) begin
        advance_square(int'(frame_if.screen_width), int'(frame_if.screen_height));
        ticks_taken++;
      end
      if (edge_if.valid && edge_if.ready) begin
        if (pending_edges.size() == 0) begin
          log_failure($sformatf("edge beat (%0d,%0d)-(%0d,%0d) with no frame tick pending",
                                edge_if.edge_start_x, edge_if.edge_start_y,
                                edge_if.edge_end_x, edge_if.edge_end_y));
        end else begin
          want = pending_edges.pop_front();
          check_field("edge_start_x", edge_if.edge_start_x, want.start_x);
          check_field("edge_start_y", edge_if.edge_start_y, want.start_y);
          check_field("edge_end_x",   edge_if.edge_end_x,   want.end_x);
          check_field("edge_end_y",   edge_if.edge_end_y,   want.end_y);
          check_field("color_red",    edge_if.color_red,    want.red);
          check_field("color_green",  edge_if.color_green,  want.green);
          check_field("color_blue",   edge_if.color_blue,   want.blue);
          check_field("last_edge",    edge_if.last_edge,    want.last_edge);
        end
        edges_checked++;
      end
    end
  end

  // The watchdog. A hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d edge beats outstanding",
               cycle_count, pending_edges.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Most gaps are short or absent, and about one in ten is long.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  // Screen sizes lean toward small screens, where the square hits the walls
  // often and the palette and spin keep changing. Medium and full-range
  // sizes, and the two extremes, make up the rest.
  function automatic logic [SCREEN_W-1:0] pick_screen_dim();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      return SCREEN_W'($urandom_range(0, 48));
    end else if (roll < 75) begin
      return SCREEN_W'($urandom_range(49, 600));
    end else if (roll < 92) begin
      return SCREEN_W'($urandom);
    end
    return ($urandom_range(0, 1) == 1) ? {SCREEN_W{1'b1}} : '0;
  endfunction

  // Offers one frame tick after an optional gap, and returns at the edge
  // where it is taken. Valid is left high, so a following tick with no gap
  // goes out back to back. During a gap the payload carries junk.
  task automatic send_frame(input logic [SCREEN_W-1:0] width,
                            input logic [SCREEN_W-1:0] height, input int gap);
    if (gap > 0) begin
      frame_if.valid         <= 1'b0;
      frame_if.screen_width  <= SCREEN_W'($urandom);
      frame_if.screen_height <= SCREEN_W'($urandom);
      repeat (gap) @(posedge clk);
    end
    frame_if.valid         <= 1'b1;
    frame_if.screen_width  <= width;
    frame_if.screen_height <= height;
    @(posedge clk);
    while (!frame_if.ready) @(posedge clk);
  endtask

  // Stops offering ticks and waits until every predicted edge has been seen.
  // Every tick yields edges, so once the queue is empty the block is idle.
  task automatic wait_for_idle();
    frame_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_edges.size() != 0) @(posedge clk);
  endtask

  // Each APB transfer is a setup phase and then an access phase; the bus then
  // idles, so that a next transfer never drives psel in the same step.
  task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == RADIUS_ADDR) begin
      square_radius = int'(data[RADIUS_W-1:0]);
      radius_writes++;
    end
    @(posedge clk);
  endtask

  task automatic apb_check_radius();
    logic [PDATA_W-1:0] readback;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= RADIUS_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== PDATA_W'(square_radius)) begin
      log_failure($sformatf("square_radius read back as %0d, expected %0d",
                            readback, square_radius));
    end
    @(posedge clk);
  endtask

  task automatic set_radius(input int radius);
    wait_for_idle();
    apb_write(RADIUS_ADDR, PDATA_W'(radius));
    apb_check_radius();
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Just out of reset the radius should read 200. On a full-size screen the
  // square starts 10 pixels from the corner, so some of its corners lie off
  // screen at negative coordinates. This exercises truncation toward zero.
  task automatic test_reset_state();
    apb_check_radius();
    for (int i = 0; i < 3; i++) begin
      send_frame('1, '1, pick_gap());
    end
    wait_for_idle();
  endtask

  // A radius of zero collapses every corner onto the center, and the largest
  // radius gives the widest corners. A write to the unmapped word must leave
  // the radius as it was.
  task automatic test_radius_extremes();
    set_radius(0);
    send_frame('1, '1, 0);
    send_frame(SCREEN_W'(2048), SCREEN_W'(2047), 0);
    set_radius((1 << RADIUS_W) - 1);
    send_frame('1, '1, 0);
    send_frame(SCREEN_W'(1365), SCREEN_W'(2730), 0);
    wait_for_idle();
    apb_write(UNUSED_ADDR, PDATA_W'(5));
    apb_check_radius();
    send_frame('1, '1, 1);
    wait_for_idle();
  endtask

  // Screen bounds at their edges. A zero-size screen pins the center at 0
  // and bounces the square on every tick. Sizes of 1 and 2 pixels keep it
  // bouncing. Screens that are zero on one axis and full on the other
  // split the two axes, and a full screen at the end lets the square move
  // off the wall again.
  task automatic test_screen_bounds();
    set_radius(DEFAULT_RADIUS);
    send_frame('0, '0, 0);
    send_frame('0, '0, 2);
    send_frame(SCREEN_W'(1), SCREEN_W'(1), 0);
    send_frame(SCREEN_W'(1), SCREEN_W'(1), 0);
    send_frame('0, '1, 0);
    send_frame('1, '0, 1);
    send_frame(SCREEN_W'(2), '1, 0);
    send_frame('1, SCREEN_W'(2), 0);
    send_frame('1, '1, 0);
    send_frame('1, '1, 3);
    wait_for_idle();
  endtask

  // The main random part. Sizes and gaps on both sides are random under one
  // radius setting per call.
  task automatic test_random_frames(input int radius, input int count);
    set_radius(radius);
    for (int i = 0; i < count; i++) begin
      send_frame(pick_screen_dim(), pick_screen_dim(), pick_gap());
    end
    wait_for_idle();
  endtask

  // The receiver stops for a long stretch while ticks keep coming with no
  // gap. The block's few stages fill up, and frame_in.ready has to drop
  // until the receiver takes beats again.
  task automatic test_backpressure();
    set_radius($urandom_range(1, (1 << RADIUS_W) - 2));
    hold_off_request = 1'b1;
    for (int i = 0; i < 24; i++) begin
      send_frame(pick_screen_dim(), pick_screen_dim(), 0);
    end
    wait_for_idle();
  endtask

  // Both sides run at full speed, so the block runs at its rated pace of one
  // edge per cycle, on small screens that bounce often.
  task automatic test_full_rate();
    set_radius(DEFAULT_RADIUS);
    ready_steady = 1'b1;
    for (int i = 0; i < 30; i++) begin
      send_frame(SCREEN_W'($urandom_range(0, 24)), SCREEN_W'($urandom_range(0, 24)), 0);
    end
    wait_for_idle();
    ready_steady = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Receiver
  // --------------------------------------------------------------------------

  // Ready alternates between runs of high and gaps of random length, unless
  // a test wants it held steady or asks for a long hold-off. Every branch
  // drives ready and then waits on the clock before the loop goes round again.
  initial begin
    int run;
    int gap;
    edge_if.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_off_request) begin
        edge_if.ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        hold_off_request = 1'b0;
      end else if (ready_steady) begin
        edge_if.ready <= 1'b1;
        @(posedge clk);
      end else begin
        run = $urandom_range(1, 12);
        edge_if.ready <= 1'b1;
        repeat (run) @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
          edge_if.ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    failures         = 0;
    cycle_count      = 0;
    ticks_taken      = 0;
    edges_checked    = 0;
    bounce_count     = 0;
    radius_writes    = 0;
    hold_off_request = 1'b0;
    ready_steady     = 1'b0;
    reset_square();

    rst                    = 1'b1;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    frame_if.valid         = 1'b0;
    frame_if.screen_width  = '0;
    frame_if.screen_height = '0;

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_state();
    test_radius_extremes();
    test_screen_bounds();
    test_random_frames((1 << RADIUS_W) - 1, 90);
    test_random_frames(0, 80);
    test_random_frames($urandom_range(1, (1 << RADIUS_W) - 2), 90);
    test_random_frames($urandom_range(1, 300), 90);
    test_backpressure();
    test_full_rate();

    // Everything has been offered. Wait for the last edges, then give the
    // block a few more cycles to show any beat that it should not send.
    wait_for_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d frame ticks and %0d edge beats, with %0d bounces,",
             ticks_taken, edges_checked, bounce_count);
    $display("under %0d radius writes, including both radius extremes and zero-size screens.",
             radius_writes);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/brs_pkg.sv
hdl/brs_if.sv
hdl/brs_motion.sv
hdl/brs_edge_gen.sv
hdl/bouncing_rotating_square.sv
verif/tb_bouncing_rotating_square.sv
